### rtl/monte_carlo_average_price_call_assert.svh
// Assertion macros for the Monte Carlo average price call RTL.
// Expects aclk and aresetn in the scope of the including module.
`ifndef MONTE_CARLO_AVERAGE_PRICE_CALL_ASSERT_SVH
`define MONTE_CARLO_AVERAGE_PRICE_CALL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MCAP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mcap assertion failed");
`define MCAP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("mcap assertion failed");
`else
`define MCAP_ASSERT(lbl, prop)
`define MCAP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/mcap_pkg.sv
// Types, constants and tables for the Monte Carlo average price call block.
// No dependencies.
package mcap_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SPOT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIKE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATHS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 3'd6;

    localparam int STEPS_W = 13;
    localparam int PATHS_W = 17;
    localparam int DISC_W  = 17;
    localparam int SUM_W   = 48;

    localparam logic [31:0] SPOT_RESET   = 32'd6553600;
    localparam logic [31:0] STRIKE_RESET = 32'd6553600;
    localparam logic [DISC_W-1:0] DISC_ONE = 17'd65536;

    // log2(e) in Q2.30
    localparam logic signed [63:0] LOG2E_Q30 = 64'sd1549082005;

    // Taylor terms ln2^k/k! in Q2.30
    function automatic logic [30:0] exp2_coef(input logic [2:0] k);
        logic [30:0] c;
        unique case (k)
            3'd0: c = 31'd1073741824;
            3'd1: c = 31'd744261118;
            3'd2: c = 31'd257941248;
            3'd3: c = 31'd59597083;
            3'd4: c = 31'd10327387;
            3'd5: c = 31'd1431680;
            3'd6: c = 31'd165394;
            3'd7: c = 31'd16378;
        endcase
        return c;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOG, ST_EXPY, ST_HORN, ST_SCALE, ST_ACC,
        ST_MDIV, ST_MWAIT, ST_PAYOFF, ST_ADIV, ST_AWAIT, ST_EST, ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic do_log;
        logic do_expy;
        logic do_horner;
        logic do_scale;
        logic do_acc;
        logic div_mean;
        logic div_avg;
        logic do_payoff;
        logic do_est;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic path_end;
        logic run_end;
        logic horner_last;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

### rtl/mcap_div.sv
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 17-bit divisor.
// Depends on mcap_pkg.
module mcap_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mcap_pkg::SUM_W-1:0]    dividend,
    input  logic [mcap_pkg::PATHS_W-1:0]  divisor,
    output logic                          done,
    output logic [mcap_pkg::SUM_W-1:0]    quotient
);
    import mcap_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic               busy_reg, done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PATHS_W-1:0] rem_reg, dvs_reg;
    logic [SUM_W-1:0]   quo_reg;

    logic [PATHS_W:0]   shifted;
    logic [PATHS_W+1:0] diff;
    logic               ge;
    logic [PATHS_W-1:0] rem_next;
    logic [SUM_W-1:0]   quo_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[SUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        ge       = !diff[PATHS_W+1];
        rem_next = ge ? diff[PATHS_W-1:0] : shifted[PATHS_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CNT_W'(SUM_W);
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/mcap_dp.sv
// Datapath: configuration registers, log price, exp by Horner, path and payoff sums.
// Depends on mcap_pkg and mcap_div.
module mcap_dp #(
    parameter int MAX_STEPS = 4096,
    parameter int MAX_PATHS = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mcap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic [15:0]                     sample,
    input  mcap_pkg::cmd_t                  cmd,
    output mcap_pkg::sts_t                  sts,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [63:0]                     m_tdata,
    output logic                            m_tlast
);
    import mcap_pkg::*;

    localparam logic [STEPS_W-1:0] STEP_CAP =
        STEPS_W'((MAX_STEPS > 8191) ? 8191 : MAX_STEPS);
    localparam logic [PATHS_W-1:0] PATH_CAP =
        PATHS_W'((MAX_PATHS > 131071) ? 131071 : MAX_PATHS);

    // configuration
    logic [31:0]         spot_reg, strike_reg, vol_reg;
    logic signed [31:0]  drift_reg;
    logic [STEPS_W-1:0]  steps_reg;
    logic [PATHS_W-1:0]  paths_reg;
    logic [DISC_W-1:0]   disc_reg;

    // working state
    logic signed [15:0]  sample_reg;
    logic signed [31:0]  log_sum_reg;
    logic signed [33:0]  y_reg;
    logic [31:0]         p_reg;
    logic [2:0]          k_reg;
    logic [63:0]         prod_reg;
    logic [SUM_W-1:0]    path_sum_reg, payoff_sum_reg;
    logic [STEPS_W-1:0]  step_idx_reg;
    logic [PATHS_W-1:0]  path_idx_reg;
    logic [31:0]         payoff_reg, est_reg;
    logic                m_tvalid_reg, m_tlast_reg;
    logic [63:0]         m_tdata_reg;

    logic [STEPS_W-1:0]  steps_eff;
    logic [PATHS_W-1:0]  paths_eff;
    logic [DISC_W-1:0]   disc_eff;

    always_comb begin
        if (steps_reg == '0)           steps_eff = STEPS_W'(1);
        else if (steps_reg > STEP_CAP) steps_eff = STEP_CAP;
        else                           steps_eff = steps_reg;
        if (paths_reg == '0)           paths_eff = PATHS_W'(1);
        else if (paths_reg > PATH_CAP) paths_eff = PATH_CAP;
        else                           paths_eff = paths_reg;
        disc_eff = (disc_reg > DISC_ONE) ? DISC_ONE : disc_reg;
    end

    // log increment with rounding, saturated log sum
    logic signed [48:0] vs_prod;
    logic signed [48:0] vs_rnd;
    logic signed [38:0] log_wide;
    logic signed [31:0] log_next;

    always_comb begin
        vs_prod  = $signed({1'b0, vol_reg}) * sample_reg;
        vs_rnd   = (vs_prod + 49'sd2048) >>> 12;
        log_wide = 39'(log_sum_reg) + 39'(drift_reg) + vs_rnd[38:0];
        if (log_wide > 39'sd2147483647)       log_next = 32'sh7FFFFFFF;
        else if (log_wide < -39'sd2147483648) log_next = 32'sh80000000;
        else                                  log_next = log_wide[31:0];
    end

    // base-2 exponent of the log sum
    logic signed [63:0] ly_prod;
    logic signed [63:0] ly_shift;
    always_comb begin
        ly_prod  = 64'(log_sum_reg) * LOG2E_Q30;
        ly_shift = ly_prod >>> 30;
    end

    logic signed [17:0] exp_int;
    logic [15:0]        exp_frac;
    assign exp_int  = y_reg[33:16];
    assign exp_frac = y_reg[15:0];

    // one Horner step
    logic [47:0] pf;
    logic [32:0] p_wide;
    always_comb begin
        pf     = p_reg * exp_frac;
        p_wide = {2'b00, exp2_coef(k_reg)} + {1'b0, pf[47:16]};
    end

    // scale by 2^n and accumulate
    logic signed [18:0] sh;
    logic [63:0]        shifted;
    logic [31:0]        price;
    logic [SUM_W:0]     path_add;
    always_comb begin
        sh      = 19'sd30 - 19'(exp_int);
        shifted = prod_reg >> sh[5:0];
        if (spot_reg == '0)           price = '0;
        else if (sh > 19'sd63)        price = '0;
        else if (sh >= 19'sd0)        price = (|shifted[63:32]) ? '1 : shifted[31:0];
        else if (sh == -19'sd1)       price = (|prod_reg[63:31]) ? '1 :
                                              {prod_reg[30:0], 1'b0};
        else                          price = '1;
        path_add = {1'b0, path_sum_reg} + (SUM_W+1)'(price);
    end

    // shared divider
    logic             div_done;
    logic [SUM_W-1:0] quotient;
    mcap_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_mean | cmd.div_avg),
        .dividend (cmd.div_avg ? payoff_sum_reg : path_sum_reg),
        .divisor  (cmd.div_avg ? paths_eff : PATHS_W'(steps_eff)),
        .done     (div_done),
        .quotient (quotient)
    );

    logic [31:0]    mean, payoff_next;
    logic [SUM_W:0] payoff_add;
    logic [64:0]    avg_disc;
    logic [31:0]    est_next;
    always_comb begin
        mean        = (|quotient[SUM_W-1:32]) ? '1 : quotient[31:0];
        payoff_next = (mean > strike_reg) ? mean - strike_reg : '0;
        payoff_add  = {1'b0, payoff_sum_reg} + (SUM_W+1)'(payoff_next);
        avg_disc    = quotient * disc_eff;
        est_next    = (|avg_disc[64:48]) ? '1 : avg_disc[47:16];
    end

    always_comb begin
        sts.path_end    = ({1'b0, step_idx_reg} + (STEPS_W+1)'(1)) >= {1'b0, steps_eff};
        sts.run_end     = ({1'b0, path_idx_reg} + (PATHS_W+1)'(1)) >= {1'b0, paths_eff};
        sts.horner_last = (k_reg == 3'd0);
        sts.div_done    = div_done;
        sts.out_free    = !m_tvalid_reg || m_tready;
    end

    // configuration and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spot_reg       <= SPOT_RESET;
            strike_reg     <= STRIKE_RESET;
            drift_reg      <= '0;
            vol_reg        <= '0;
            steps_reg      <= STEPS_W'(1);
            paths_reg      <= PATHS_W'(1);
            disc_reg       <= DISC_ONE;
            log_sum_reg    <= '0;
            path_sum_reg   <= '0;
            payoff_sum_reg <= '0;
            step_idx_reg   <= '0;
            path_idx_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SPOT:     spot_reg   <= cfg_wdata;
                    REG_STRIKE:   strike_reg <= cfg_wdata;
                    REG_DRIFT:    drift_reg  <= cfg_wdata;
                    REG_VOL:      vol_reg    <= cfg_wdata;
                    REG_STEPS:    steps_reg  <= cfg_wdata[STEPS_W-1:0];
                    REG_PATHS:    paths_reg  <= cfg_wdata[PATHS_W-1:0];
                    REG_DISCOUNT: disc_reg   <= cfg_wdata[DISC_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.do_log) log_sum_reg <= log_next;
            if (cmd.do_acc) begin
                path_sum_reg <= path_add[SUM_W] ? '1 : path_add[SUM_W-1:0];
                if (!sts.path_end) step_idx_reg <= step_idx_reg + STEPS_W'(1);
            end
            if (cmd.do_payoff) begin
                payoff_sum_reg <= payoff_add[SUM_W] ? '1 : payoff_add[SUM_W-1:0];
                step_idx_reg   <= '0;
                log_sum_reg    <= '0;
                path_sum_reg   <= '0;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
                if (sts.run_end) begin
                    path_idx_reg   <= '0;
                    payoff_sum_reg <= '0;
                end else begin
                    path_idx_reg <= path_idx_reg + PATHS_W'(1);
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture)   sample_reg <= sample;
        if (cmd.do_expy) begin
            y_reg <= ly_shift[33:0];
            p_reg <= {1'b0, exp2_coef(3'd7)};
            k_reg <= 3'd6;
        end
        if (cmd.do_horner) begin
            p_reg <= p_wide[31:0];
            k_reg <= k_reg - 3'd1;
        end
        if (cmd.do_scale)  prod_reg   <= spot_reg * p_reg;
        if (cmd.do_payoff) payoff_reg <= payoff_next;
        if (cmd.do_est)    est_reg    <= est_next;
        if (cmd.load_out) begin
            m_tdata_reg <= {sts.run_end ? est_reg : 32'd0, payoff_reg};
            m_tlast_reg <= sts.run_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/mcap_ctrl.sv
// Controller state machine sequencing the datapath per sample and per path.
// Depends on mcap_pkg and the assertion macro header.
`include "monte_carlo_average_price_call_assert.svh"
module mcap_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mcap_pkg::sts_t sts,
    output mcap_pkg::cmd_t cmd
);
    import mcap_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOG;
            ST_LOG:    state_next = ST_EXPY;
            ST_EXPY:   state_next = ST_HORN;
            ST_HORN:   if (sts.horner_last) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_ACC;
            ST_ACC:    state_next = sts.path_end ? ST_MDIV : ST_IDLE;
            ST_MDIV:   state_next = ST_MWAIT;
            ST_MWAIT:  if (sts.div_done) state_next = ST_PAYOFF;
            ST_PAYOFF: state_next = sts.run_end ? ST_ADIV : ST_EMIT;
            ST_ADIV:   state_next = ST_AWAIT;
            ST_AWAIT:  if (sts.div_done) state_next = ST_EST;
            ST_EST:    state_next = ST_EMIT;
            ST_EMIT:   if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOG:    cmd.do_log    = 1'b1;
            ST_EXPY:   cmd.do_expy   = 1'b1;
            ST_HORN:   cmd.do_horner = 1'b1;
            ST_SCALE:  cmd.do_scale  = 1'b1;
            ST_ACC:    cmd.do_acc    = 1'b1;
            ST_MDIV:   cmd.div_mean  = 1'b1;
            ST_PAYOFF: cmd.do_payoff = 1'b1;
            ST_ADIV:   cmd.div_avg   = 1'b1;
            ST_EST:    cmd.do_est    = 1'b1;
            ST_EMIT:   cmd.load_out  = sts.out_free;
            default: ;
        endcase
    end

    `MCAP_ASSERT_ALWAYS(a_cmd_excl, $onehot0({cmd.capture, cmd.div_mean, cmd.div_avg, cmd.load_out}))
    `MCAP_ASSERT(a_mid_path_idle, (state_reg == ST_ACC && !sts.path_end) |=> (state_reg == ST_IDLE))
    `MCAP_ASSERT(a_emit_done, (state_reg == ST_EMIT && sts.out_free) |=> (state_reg == ST_IDLE))

endmodule

### rtl/monte_carlo_average_price_call.sv
// Sample input: each transaction passes a log step, exp set-up, seven Horner steps
// of the shared 32x16 multiplier, scale and accumulate before the next is accepted.
// A path's last sample adds the one-bit-per-cycle mean division; a run's last path
// adds a second division for the payoff average. A result is loaded into the output
// register once it is free and waits there until taken. Reset is synchronous, active
// low: configuration returns to its defaults, sums and step/path counters clear, no result is pending.
module monte_carlo_average_price_call #(
    parameter int MAX_STEPS = 4096,
    parameter int MAX_PATHS = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mcap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] normal_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // [31:0] path_payoff, [63:32] price_estimate
    output logic                            m_tlast    // run_done
);
    import mcap_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mcap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcap_dp #(
        .MAX_STEPS (MAX_STEPS),
        .MAX_PATHS (MAX_PATHS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### tb/monte_carlo_average_price_call_checker.sv
// Checker for the Monte Carlo average price call block: watches the sample and
// result streams and the register port, predicts each path result and compares.
// Depends on mcap_pkg.
`timescale 1ns / 1ps

module monte_carlo_average_price_call_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          runs_seen
);
    import mcap_pkg::*;

    localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;
    localparam longint MAX_STEP_CNT = 4096;
    localparam longint MAX_PATH_CNT = 65536;

    typedef struct packed {
        logic [31:0] payoff;
        logic [31:0] estimate;
        logic        done;
    } path_result_t;

    logic [31:0] spot, strike, drift, vol;
    logic [12:0] steps_reg;
    logic [16:0] paths_reg, disc_reg;

    longint      log_sum;
    logic [47:0] price_sum, payoff_acc;
    longint      step_cnt, path_cnt;
    path_result_t expected_q[$];

    function automatic longint floor_div_pow2(longint v, int k);
        return v >>> k;
    endfunction

    function automatic logic [31:0] clamp32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? SUM_SAT : s[47:0];
    endfunction

    function automatic logic [31:0] price_from_log(longint lg);
        longint      y, n, sh;
        logic [63:0] f, p, prod;
        longint      coef[8];
        coef = '{1073741824, 744261118, 257941248, 59597083,
                 10327387, 1431680, 165394, 16378};
        y = floor_div_pow2(lg * 64'sd1549082005, 30);
        n = floor_div_pow2(y, 16);
        f = y - n * 65536;
        p = coef[7];
        for (int k = 6; k >= 0; k--) p = coef[k] + ((p * f) >> 16);
        if (spot == 0) return 32'd0;
        prod = {32'd0, spot} * p;
        sh = 30 - n;
        if (sh > 63) return 32'd0;
        if (sh >= 0) return clamp32(prod >> sh);
        if (sh == -1) return clamp32(prod << 1);
        return 32'hFFFF_FFFF;
    endfunction

    // Advance the path state by one sample; queue a result at path end.
    task automatic advance_path(logic signed [15:0] sample);
        longint       steps, paths, disc, inc, nl;
        logic [63:0]  mean, avg;
        path_result_t r;
        steps = (steps_reg == 0) ? 1 : steps_reg;
        if (steps > MAX_STEP_CNT) steps = MAX_STEP_CNT;
        paths = (paths_reg == 0) ? 1 : paths_reg;
        if (paths > MAX_PATH_CNT) paths = MAX_PATH_CNT;
        disc = (disc_reg > 65536) ? 65536 : disc_reg;
        inc = longint'($signed(drift))
            + floor_div_pow2(longint'(vol) * longint'(sample) + 2048, 12);
        nl = log_sum + inc;
        if (nl > 64'sd2147483647) nl = 64'sd2147483647;
        if (nl < -64'sd2147483648) nl = -64'sd2147483648;
        log_sum = nl;
        price_sum = add_sat48(price_sum, {16'd0, price_from_log(nl)});
        if (step_cnt + 1 < steps) begin
            step_cnt++;
            return;
        end
        mean = clamp32(price_sum / steps);
        r.payoff = (mean[31:0] > strike) ? mean[31:0] - strike : 32'd0;
        r.estimate = '0;
        r.done = 1'b0;
        payoff_acc = add_sat48(payoff_acc, {16'd0, r.payoff});
        step_cnt = 0;
        log_sum = 0;
        price_sum = '0;
        if (path_cnt + 1 >= paths) begin
            avg = payoff_acc / paths;
            r.estimate = clamp32((avg * disc) >> 16);
            r.done = 1'b1;
            path_cnt = 0;
            payoff_acc = '0;
        end else begin
            path_cnt++;
        end
        expected_q = {expected_q, r};
    endtask

    always @(posedge aclk) begin
        path_result_t exp_r;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            spot = SPOT_RESET;
            strike = STRIKE_RESET;
            drift = '0;
            vol = '0;
            steps_reg = 13'd1;
            paths_reg = 17'd1;
            disc_reg = DISC_ONE;
            log_sum = 0;
            price_sum = '0;
            payoff_acc = '0;
            step_cnt = 0;
            path_cnt = 0;
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
            runs_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SPOT:     spot = cfg_wdata;
                    REG_STRIKE:   strike = cfg_wdata;
                    REG_DRIFT:    drift = cfg_wdata;
                    REG_VOL:      vol = cfg_wdata;
                    REG_STEPS:    steps_reg = cfg_wdata[12:0];
                    REG_PATHS:    paths_reg = cfg_wdata[16:0];
                    REG_DISCOUNT: disc_reg = cfg_wdata[16:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (m_tlast) runs_seen <= runs_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: data %h last %b", m_tdata, m_tlast);
                    errs++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_tdata[31:0] !== exp_r.payoff) begin
                        $error("path_payoff: expected %h, actual %h", exp_r.payoff, m_tdata[31:0]);
                        errs++;
                    end
                    if (m_tdata[63:32] !== exp_r.estimate) begin
                        $error("price_estimate: expected %h, actual %h",
                               exp_r.estimate, m_tdata[63:32]);
                        errs++;
                    end
                    if (m_tlast !== exp_r.done) begin
                        $error("run_done: expected %b, actual %b", exp_r.done, m_tlast);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
            if (s_tvalid && s_tready) advance_path(s_tdata);
        end
        pending <= expected_q.size();
    end
endmodule

### tb/monte_carlo_average_price_call_tb.sv
// Top of the Monte Carlo average price call testbench: clock, reset, register
// writes, sample stimulus and result back-pressure. Depends on mcap_pkg, the
// block and monte_carlo_average_price_call_checker.
`timescale 1ns / 1ps

module monte_carlo_average_price_call_tb;
    import mcap_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    int  fail_count, pending, results_seen, runs_seen;
    int  samples_sent = 0;
    int  idle_cycles = 0;
    bit  hold_results = 1'b0;

    always #6 aclk = ~aclk;

    monte_carlo_average_price_call u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    monte_carlo_average_price_call_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .runs_seen(runs_seen)
    );

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold valid across back-to-back transactions; drop it only for a gap.
    task automatic send_sample(logic [15:0] val, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= val;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        @(negedge aclk);
    endtask

    // Wait for every predicted result, then idle while the last sample finishes in the block.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // Receiver back-pressure: per-transaction stall, or a long hold on request.
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_results = 1'b0;
            end else begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [31:0] set_spot, set_strike, set_drift, set_vol, set_steps, set_paths, set_disc;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, field extremes.
        send_sample(16'h0000, 0);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        send_sample(16'hFFFF, 0);
        drain();

        // Directed: volatile path with several steps and paths, zero counts.
        write_reg(REG_VOL, 32'h0000_4000);
        write_reg(REG_DRIFT, 32'hFFFF_F000);
        write_reg(REG_STEPS, 32'd3);
        write_reg(REG_PATHS, 32'd2);
        write_reg(REG_DISCOUNT, 32'd60000);
        for (int i = 0; i < 6; i++) send_sample(random_sample(), 0);
        drain();
        write_reg(REG_STEPS, 32'd0);
        write_reg(REG_PATHS, 32'd0);
        write_reg(REG_DISCOUNT, 32'h1FFFF);
        write_reg(REG_STRIKE, 32'd0);
        send_sample(16'h1234, 0);
        send_sample(16'hEDCC, 0);
        drain();
        // Extreme log drift saturates the price; zero spot gives zero.
        write_reg(REG_DRIFT, 32'h7FFF_FFFF);
        write_reg(REG_VOL, 32'hFFFF_FFFF);
        write_reg(REG_SPOT, 32'hFFFF_FFFF);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        drain();
        write_reg(REG_DRIFT, 32'h8000_0000);
        send_sample(16'h8000, 0);
        drain();
        write_reg(REG_SPOT, 32'd0);
        send_sample(16'h0001, 0);
        drain();
        // Counts above the limits clamp; lowering a count mid-path ends it.
        write_reg(REG_SPOT, 32'd6553600);
        write_reg(REG_DRIFT, 32'd0);
        write_reg(REG_VOL, 32'd13107);
        write_reg(REG_STEPS, 32'h1FFF);
        write_reg(REG_PATHS, 32'h1FFFF);
        send_sample(16'h0400, 0);
        send_sample(16'hFC00, 0);
        drain();
        write_reg(REG_STEPS, 32'd1);
        send_sample(16'h0000, 0);
        drain();
        write_reg(REG_PATHS, 32'd1);
        send_sample(16'h0000, 0);
        drain();

        // Random phases: fresh settings, a few runs of small paths each.
        for (int ph = 0; ph < 24; ph++) begin
            set_spot = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1 << 16, 200 << 16);
            set_strike = ($urandom_range(0, 7) == 0) ? $urandom() : set_spot + $urandom_range(0, 1 << 20) - (1 << 19);
            set_drift = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 2000) - 1000;
            set_vol = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 16000);
            set_steps = $urandom_range(1, 8);
            set_paths = $urandom_range(1, 6);
            set_disc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071) : $urandom_range(50000, 65536);
            write_reg(REG_SPOT, set_spot);
            write_reg(REG_STRIKE, set_strike);
            write_reg(REG_DRIFT, set_drift);
            write_reg(REG_VOL, set_vol);
            write_reg(REG_STEPS, set_steps);
            write_reg(REG_PATHS, set_paths);
            write_reg(REG_DISCOUNT, set_disc);
            // Hold off the receiver for a long stretch in one phase so the block backs up.
            if (ph == 5) hold_results = 1'b1;
            for (int i = 0; i < 52; i++) begin
                send_sample(random_sample(), ph == 5);
            end
            drain();
        end

        $display("Covered %0d samples, %0d path results, %0d completed runs,",
                 samples_sent, results_seen, runs_seen);
        $display("with register extremes, count clamping and mid-path count changes.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
